// ===== rtl/core/fde_pkg.sv =====
// Shared types and constants of the finite-difference extrapolator.
package fde_pkg;

    localparam int FDE_MAX_LEN = 32;
    localparam int SAMPLE_W    = 32;
    localparam int DATA_W      = 64;
    localparam int NUM_BANKS   = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DATA_W-1:0]   t_data;

endpackage

// ===== rtl/core/fde_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fde_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fde_front.sv =====
// Front part: takes samples, writes them into the current bank and issues a job per sequence.
module fde_front #(
    parameter int MAX_LEN = 32,
    parameter int LW      = $clog2(MAX_LEN + 1),
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  fde_pkg::t_sample     i_sample,
    input  logic                 i_end_of_sequence,
    output logic                 o_we,
    output logic                 o_wbank,
    output logic [AW-1:0]        o_waddr,
    output fde_pkg::t_data       o_wdata,
    output logic                 o_job_push,
    output logic [LW+1:0]        o_job
);
    import fde_pkg::*;

    logic [LW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_wbank, n_wbank;
    logic          room;
    logic [LW-1:0] len_after;
    logic          ovf_after;

    assign room      = (r_count < LW'(MAX_LEN));
    assign len_after = room ? r_count + 1'b1 : r_count;
    assign ovf_after = r_ovf | ~room;

    assign o_we       = i_accept & room;
    assign o_wbank    = r_wbank;
    assign o_waddr    = r_count[AW-1:0];
    assign o_wdata    = {{(DATA_W - SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample};
    assign o_job_push = i_accept & i_end_of_sequence;
    assign o_job      = {r_wbank, ovf_after, len_after};

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_wbank = r_wbank;
        if (i_accept) begin
            if (i_end_of_sequence) begin
                // The sequence is handed over; the next one goes to the other bank.
                n_count = '0;
                n_ovf   = 1'b0;
                n_wbank = ~r_wbank;
            end else begin
                n_count = len_after;
                n_ovf   = ovf_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_wbank <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_wbank <= n_wbank;
        end
    end

endmodule

// ===== rtl/core/fde_job_queue.sv =====
// Two-entry job queue between the front and back parts.
module fde_job_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== rtl/core/fde_back.sv =====
// Back part: runs the difference table of one bank row by row and holds the result item.
module fde_back #(
    parameter int MAX_LEN = 32,
    parameter int LW      = $clog2(MAX_LEN + 1),
    parameter int AW      = $clog2(MAX_LEN)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  logic [LW+1:0]    i_job,
    output logic             o_job_pop,
    output logic             o_bank,
    output logic [AW-1:0]    o_raddr,
    input  fde_pkg::t_data   i_rdata,
    output logic             o_we,
    output logic [AW-1:0]    o_waddr,
    output fde_pkg::t_data   o_wdata,
    input  logic             i_pop,
    output logic             o_empty,
    output fde_pkg::t_data   o_next_value,
    output fde_pkg::t_data   o_previous_value,
    output logic             o_too_long
);
    import fde_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_END  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    r_state;
    logic [LW-1:0] r_len, r_idx, r_pend_idx;
    logic          r_pend;
    logic          r_bank, r_too;
    logic          r_nz, r_sub;
    t_data         r_first, r_last, r_fwd, r_bwd;
    logic          r_out_valid, r_out_too;
    t_data         r_out_next, r_out_prev;
    logic [LW-1:0] wr_idx;
    logic          load_out;
    t_data         n_fwd, n_bwd;

    assign o_bank  = r_bank;
    assign o_raddr = r_idx[AW-1:0];

    // Each element read after the first replaces its left neighbour by the difference.
    assign wr_idx  = r_pend_idx - 1'b1;
    assign o_we    = r_pend & (r_pend_idx != '0);
    assign o_waddr = wr_idx[AW-1:0];
    assign o_wdata = i_rdata - r_last;

    assign n_fwd = r_fwd + r_last;
    assign n_bwd = r_sub ? r_bwd - r_first : r_bwd + r_first;

    assign load_out  = (r_state == S_OUT) & (~r_out_valid | i_pop);
    assign o_job_pop = load_out;

    assign o_empty          = ~r_out_valid;
    assign o_next_value     = r_out_next;
    assign o_previous_value = r_out_prev;
    assign o_too_long       = r_out_too;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_RUN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_idx == r_len - 1'b1) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_END;
                end
                S_END: begin
                    if (!r_nz || r_len == LW'(1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx;
        if (r_pend) begin
            if (r_pend_idx == '0) begin
                r_first <= i_rdata;
            end
            r_last <= i_rdata;
            if (i_rdata != '0) begin
                r_nz <= 1'b1;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                {r_bank, r_too, r_len} <= i_job;
                r_idx <= '0;
                r_nz  <= 1'b0;
                r_sub <= 1'b0;
                r_fwd <= '0;
                r_bwd <= '0;
            end
            S_RUN: begin
                r_idx <= r_idx + 1'b1;
            end
            S_WAIT: begin
            end
            S_END: begin
                // A row of zeros adds nothing, so the sums are updated unconditionally.
                r_fwd <= n_fwd;
                r_bwd <= n_bwd;
                r_sub <= ~r_sub;
                r_len <= r_len - 1'b1;
                r_idx <= '0;
                r_nz  <= 1'b0;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_next <= r_fwd;
            r_out_prev <= r_bwd;
            r_out_too  <= r_too;
        end
    end

endmodule

// ===== rtl/core/finite_difference_extrapolator_unit.sv =====
// Top level of the finite-difference extrapolator.
//
// Samples enter on a queue-like port: an item is taken when push is high and full is low.
// Each sample is stored one per cycle; the item with i_end_of_sequence set closes the
// sequence and causes exactly one result item, earlier items cause none. Samples beyond
// MAX_LEN are dropped and the result then shows o_too_long.
// Results leave on a queue-like port: the result is on the outputs while empty is low and
// is taken when pop is high. A stalled result simply waits in the output register.
// A sequence is worked off in its bank row by row, each row being read in S_RUN and
// closed through S_WAIT and S_END, until a row reads as all zeros or is one element long.
// The row store has two banks, so the next sequence is loaded while the previous one is
// worked off; full rises only when the queue holds two jobs, one still in the back part.
// Reset is synchronous and active low; it empties the job queue and the result port.
// The row store needs no clearing, as every entry is written before it is read.
module finite_difference_extrapolator_unit #(
    parameter int MAX_LEN = fde_pkg::FDE_MAX_LEN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  fde_pkg::t_sample i_sample,
    input  logic             i_end_of_sequence,
    input  logic             pop,
    output logic             empty,
    output fde_pkg::t_data   o_next_value,
    output fde_pkg::t_data   o_previous_value,
    output logic             o_too_long
);
    import fde_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int JW = LW + 2;

    logic          accept;
    logic          f_we, f_wbank;
    logic [AW-1:0] f_waddr;
    t_data         f_wdata;
    logic          job_push, job_pop, job_valid, job_full;
    logic [JW-1:0] job_in, job_out;
    logic          b_bank, b_we;
    logic [AW-1:0] b_raddr, b_waddr;
    t_data         b_wdata;
    t_data         bank_rdata [NUM_BANKS];

    assign accept = push & ~job_full;
    assign full   = job_full;

    fde_front #(.MAX_LEN(MAX_LEN), .LW(LW), .AW(AW)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_sample          (i_sample),
        .i_end_of_sequence (i_end_of_sequence),
        .o_we              (f_we),
        .o_wbank           (f_wbank),
        .o_waddr           (f_waddr),
        .o_wdata           (f_wdata),
        .o_job_push        (job_push),
        .o_job             (job_in)
    );

    fde_job_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_valid (job_valid),
        .o_data  (job_out)
    );

    // The front only writes while the bank it fills holds no pending job.
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic          we;
        logic [AW-1:0] waddr;
        t_data         wdata;
        logic          back_owns;

        assign back_owns = b_we && (b_bank == 1'(b));
        assign we        = back_owns || (f_we && (f_wbank == 1'(b)));
        assign waddr     = back_owns ? b_waddr : f_waddr;
        assign wdata     = back_owns ? b_wdata : f_wdata;

        fde_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LEN)) u_ram (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_raddr (b_raddr),
            .o_rdata (bank_rdata[b])
        );
    end

    fde_back #(.MAX_LEN(MAX_LEN), .LW(LW), .AW(AW)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .i_job            (job_out),
        .o_job_pop        (job_pop),
        .o_bank           (b_bank),
        .o_raddr          (b_raddr),
        .i_rdata          (bank_rdata[b_bank]),
        .o_we             (b_we),
        .o_waddr          (b_waddr),
        .o_wdata          (b_wdata),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_next_value     (o_next_value),
        .o_previous_value (o_previous_value),
        .o_too_long       (o_too_long)
    );

endmodule

// ===== rtl/core/fde_checker.sv =====
// Port-level checks of the finite-difference extrapolator and their binding.
module fde_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             i_end_of_sequence,
    input logic             pop,
    input logic             empty,
    input fde_pkg::t_data   o_next_value,
    input fde_pkg::t_data   o_previous_value,
    input logic             o_too_long
);

    // Reset leaves both sides idle.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue ports not idle after reset");

    // Only a closing item can fill the job queue.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(full) |-> $past(push && i_end_of_sequence))
        else $error("full rose without a closing item");

    // A result leaves only when it is taken.
    a_empty_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(empty) |-> $past(pop))
        else $error("result vanished without pop");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_next_value)
            && $stable(o_previous_value) && $stable(o_too_long))
        else $error("waiting result changed");

endmodule

bind finite_difference_extrapolator_unit fde_checker u_fde_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .push              (push),
    .full              (full),
    .i_end_of_sequence (i_end_of_sequence),
    .pop               (pop),
    .empty             (empty),
    .o_next_value      (o_next_value),
    .o_previous_value  (o_previous_value),
    .o_too_long        (o_too_long)
);
